// File: design/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the frame decoder RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/hsfd_pkg.sv
// hsfd_pkg: constants, status codes and the result type of the frame decoder.
// No dependencies; used by the interfaces, hsfd_frame_check and the top level.
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam int FRAME_BITS = 40;
    localparam int WIDTH_BITS = 15;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;

    localparam logic [WIDTH_BITS-1:0] THRESHOLD_RESET = WIDTH_BITS'(50);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_NO_HIGH  = 2'd2,
        ST_CHECKSUM = 2'd3
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic        [WORD_W-1:0]  humidity_tenths;
        logic signed [WORD_W-1:0]  temperature_tenths;
    } t_result;

endpackage

// File: design/hsfd_if.sv
// hsfd_sym_if / hsfd_res_if: valid/ready channels for symbol words and result words.
// Depends on hsfd_pkg for field widths.
`timescale 1ns / 1ps

interface hsfd_sym_if;
    logic                              valid;
    logic                              ready;
    logic                              first_level;
    logic [hsfd_pkg::WIDTH_BITS-1:0]   first_width;
    logic                              second_level;
    logic [hsfd_pkg::WIDTH_BITS-1:0]   second_width;
    logic                              end_of_capture;

    modport source (
        output valid, first_level, first_width, second_level, second_width, end_of_capture,
        input  ready
    );
    modport sink (
        input  valid, first_level, first_width, second_level, second_width, end_of_capture,
        output ready
    );
endinterface

interface hsfd_res_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [hsfd_pkg::WORD_W-1:0]       humidity_tenths;
    logic signed [hsfd_pkg::WORD_W-1:0] temperature_tenths;

    modport source (
        output valid, status, humidity_tenths, temperature_tenths,
        input  ready
    );
    modport sink (
        input  valid, status, humidity_tenths, temperature_tenths,
        output ready
    );
endinterface

// File: design/hsfd_bit_cell.sv
// hsfd_bit_cell: one stage of the 40-bit frame window; takes its neighbour's bit on shift.
// Depends on nothing.
`timescale 1ns / 1ps

module hsfd_bit_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_clear,
    input  logic i_bit,
    output logic o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: design/hsfd_frame_check.sv
// hsfd_frame_check: status, checksum and value extraction for a completed window.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_frame_check (
    input  logic [hsfd_pkg::FRAME_BITS-1:0] i_window,
    input  logic [hsfd_pkg::CNT_W-1:0]      i_sym_cnt,
    input  logic [hsfd_pkg::CNT_W-1:0]      i_clean_run,
    output hsfd_pkg::t_result               o_result
);

    logic [hsfd_pkg::BYTE_W-1:0] w_b0, w_b1, w_b2, w_b3, w_b4, w_sum;
    logic [hsfd_pkg::WORD_W-1:0] w_raw_t, w_mag;

    assign w_b0 = i_window[39:32];
    assign w_b1 = i_window[31:24];
    assign w_b2 = i_window[23:16];
    assign w_b3 = i_window[15:8];
    assign w_b4 = i_window[7:0];

    // checksum wraps to 8 bits
    assign w_sum   = w_b0 + w_b1 + w_b2 + w_b3;
    assign w_raw_t = {w_b2, w_b3};
    assign w_mag   = {1'b0, w_raw_t[hsfd_pkg::WORD_W-2:0]};

    always_comb begin
        o_result.status             = hsfd_pkg::ST_OK;
        o_result.humidity_tenths    = '0;
        o_result.temperature_tenths = '0;
        if (i_sym_cnt < hsfd_pkg::CNT_W'(hsfd_pkg::FRAME_BITS)) begin
            o_result.status = hsfd_pkg::ST_SHORT;
        end else if (i_clean_run < hsfd_pkg::CNT_W'(hsfd_pkg::FRAME_BITS)) begin
            o_result.status = hsfd_pkg::ST_NO_HIGH;
        end else if (w_sum != w_b4) begin
            o_result.status = hsfd_pkg::ST_CHECKSUM;
        end else begin
            o_result.humidity_tenths = {w_b0, w_b1};
            // sign-magnitude to two's complement; negative zero comes out as 0
            o_result.temperature_tenths = w_raw_t[hsfd_pkg::WORD_W-1] ? (~w_mag + 1'b1) : w_mag;
        end
    end

endmodule

// File: design/humidity_sensor_frame_decoder.sv
// humidity_sensor_frame_decoder: top level, a row of bit cells plus counters and result skid.
// Depends on hsfd_pkg, hsfd_if, hsfd_bit_cell, hsfd_frame_check, assert_macros.svh.
//
//  channel   | dir | handshake      | word
//  i_sym     | in  | valid/ready    | two level/width halves + end_of_capture
//  o_res     | out | valid/ready    | status, humidity_tenths, temperature_tenths
//  i_cfg_*   | in  | write enable   | bit_threshold (15 bits)
//
// One symbol word per cycle while i_sym.ready is high; the word that closes a capture
// has its result registered in the output register, or in the skid slot behind a stalled o_res.
// The result comes from the single compare-shift-check path into those registers.
// Reset (synchronous, active low) clears the window, counters, result valids
// and sets the threshold to 50.
// i_sym.ready only drops while the skid slot holds a result behind a stalled o_res.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module humidity_sensor_frame_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [hsfd_pkg::WIDTH_BITS-1:0] i_cfg_wr_data,
    hsfd_sym_if.sink                        i_sym,
    hsfd_res_if.source                      o_res
);

    // configuration
    logic [hsfd_pkg::WIDTH_BITS-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= hsfd_pkg::THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // symbol decode
    logic                            w_accept;
    logic                            w_last;
    logic                            w_has_high;
    logic [hsfd_pkg::WIDTH_BITS-1:0] w_high;
    logic                            w_bit;

    assign w_accept   = i_sym.valid && i_sym.ready;
    assign w_last     = i_sym.end_of_capture;
    assign w_has_high = i_sym.first_level || i_sym.second_level;
    // first half wins when both are high
    assign w_high     = i_sym.first_level ? i_sym.first_width : i_sym.second_width;
    assign w_bit      = w_has_high && (w_high > r_thr);

    // row of bit cells: cell 0 holds the newest bit
    logic [hsfd_pkg::FRAME_BITS-1:0] w_cells;
    logic [hsfd_pkg::FRAME_BITS-1:0] w_feed;
    logic [hsfd_pkg::FRAME_BITS-1:0] w_window_next;

    assign w_feed        = {w_cells[hsfd_pkg::FRAME_BITS-2:0], w_bit};
    assign w_window_next = w_feed;

    for (genvar k = 0; k < hsfd_pkg::FRAME_BITS; k++) begin : g_cell
        hsfd_bit_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_clear (w_accept && w_last),
            .i_bit   (w_feed[k]),
            .o_bit   (w_cells[k])
        );
    end

    // symbol and clean-run counters, both saturating at the frame length
    logic [hsfd_pkg::CNT_W-1:0] r_sym_cnt, n_sym_cnt;
    logic [hsfd_pkg::CNT_W-1:0] r_clean_run, n_clean_run;
    logic [hsfd_pkg::CNT_W-1:0] w_sym_inc, w_clean_inc;

    localparam logic [hsfd_pkg::CNT_W-1:0] CntFull = hsfd_pkg::CNT_W'(hsfd_pkg::FRAME_BITS);

    always_comb begin
        w_sym_inc   = (r_sym_cnt < CntFull) ? r_sym_cnt + 1'b1 : r_sym_cnt;
        w_clean_inc = !w_has_high ? '0
                    : ((r_clean_run < CntFull) ? r_clean_run + 1'b1 : r_clean_run);
        n_sym_cnt   = r_sym_cnt;
        n_clean_run = r_clean_run;
        if (w_accept) begin
            if (w_last) begin
                n_sym_cnt   = '0;
                n_clean_run = '0;
            end else begin
                n_sym_cnt   = w_sym_inc;
                n_clean_run = w_clean_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_cnt   <= '0;
            r_clean_run <= '0;
        end else begin
            r_sym_cnt   <= n_sym_cnt;
            r_clean_run <= n_clean_run;
        end
    end

    // frame check on the window as it stands after this symbol
    hsfd_pkg::t_result w_result;

    hsfd_frame_check u_check (
        .i_window    (w_window_next),
        .i_sym_cnt   (w_sym_inc),
        .i_clean_run (w_clean_inc),
        .o_result    (w_result)
    );

    // output register plus one skid slot
    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    hsfd_pkg::t_result r_out, n_out;
    hsfd_pkg::t_result r_skid, n_skid;
    logic              w_push, w_pop;

    assign w_push      = w_accept && w_last;
    assign w_pop       = r_out_valid && o_res.ready;
    assign i_sym.ready = !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_push) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_push) begin
            n_skid       = w_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.status             = r_out.status;
    assign o_res.humidity_tenths    = r_out.humidity_tenths;
    assign o_res.temperature_tenths = r_out.temperature_tenths;

    // checks
    logic w_state_clear;
    logic w_out_fail;
    logic w_out_values_zero;

    assign w_state_clear     = (r_sym_cnt == '0) && (r_clean_run == '0) && (w_cells == '0);
    assign w_out_fail        = r_out_valid && (r_out.status != hsfd_pkg::ST_OK);
    assign w_out_values_zero = (r_out.humidity_tenths == '0)
                            && (r_out.temperature_tenths == '0);

    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_IMPLIES(a_clean_le_count, i_clk, i_rst_n, 1'b1, r_clean_run <= r_sym_cnt)
    `ASSERT_NEXT(a_clear_after_end, i_clk, i_rst_n, w_accept && w_last, w_state_clear)
    `ASSERT_IMPLIES(a_fail_zero_values, i_clk, i_rst_n, w_out_fail, w_out_values_zero)

endmodule
